FILE: rtl/core/padded_integer_field_formatter_defines.svh
// Assertion macros used by the formatter's checker, pifr_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef PADDED_INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define PADDED_INTEGER_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define PIFR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PIFR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pifr_pkg.sv
// Package for the padded integer field formatter: constants, FSM state,
// unit request/response structs, digit_ascii and clamp_len. No dependencies.
`default_nettype none

package pifr_pkg;

    // Field limits and digit store sizing
    localparam logic [5:0] FMT_LIMIT   = 6'd48;
    localparam int         DIGITS_MAX  = 10;
    localparam int         DIG_IDX_W   = $clog2(DIGITS_MAX);
    localparam int         HEX_DIGIT_W = 4;

    // Divide by ten through the reciprocal: q = (x * RECIP_10) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [3:0]  DEC_BASE    = 4'd10;

    // ASCII codes
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd87;

    // Conversion codes carried in tuser
    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_PLAN,
        ST_EMIT
    } pifr_state_t;

    // Request into the shared digit unit
    typedef struct packed {
        logic        start;
        logic        hex;
        logic [31:0] mag;
    } du_req_t;

    // Response from the shared digit unit
    typedef struct packed {
        logic        done;
        logic [3:0]  digit;
        logic [31:0] quot;
    } du_rsp_t;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        return (d < DEC_BASE) ? (CH_ZERO + d8) : (HEX_ALPHA_OFS + d8);
    endfunction

    function automatic logic [5:0] clamp_len(input logic [5:0] v);
        return (v > FMT_LIMIT) ? FMT_LIMIT : v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pifr_digit_unit.sv
// Shared digit unit: splits one magnitude into quotient and low digit,
// base 10 by reciprocal multiply or base 16 by shift. Uses pifr_pkg.
`default_nettype none

module pifr_digit_unit
    import pifr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire du_req_t req,
    output du_rsp_t      rsp
);

    logic        busy_reg;
    logic        hex_reg;
    logic [31:0] mag_reg;
    logic [63:0] prod_reg;

    logic [31:0] dec_quot;
    logic [31:0] dec_times10;
    logic [31:0] dec_rem;

    // Result is ready the cycle after a start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= req.start;
        end
    end

    // Operand capture and the one multiply
    always_ff @(posedge aclk) begin
        if (req.start) begin
            hex_reg  <= req.hex;
            mag_reg  <= req.mag;
            prod_reg <= 64'(req.mag) * 64'(RECIP_10);
        end
    end

    // Quotient and remainder: rem = x - 10q, 10q as two shifts added
    always_comb begin
        dec_quot    = 32'(prod_reg >> RECIP_SHIFT);
        dec_times10 = (dec_quot << 3) + (dec_quot << 1);
        dec_rem     = mag_reg - dec_times10;
    end

    always_comb begin
        rsp.done = busy_reg;
        if (hex_reg) begin
            rsp.quot  = mag_reg >> HEX_DIGIT_W;
            rsp.digit = mag_reg[HEX_DIGIT_W-1:0];
        end else begin
            rsp.quot  = dec_quot;
            rsp.digit = dec_rem[3:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/padded_integer_field_formatter.sv
// Top level of the padded integer field formatter (%d / %x with width and
// precision). Uses pifr_pkg and pifr_digit_unit.
//
// One request describes one field; the block answers with its ASCII bytes, one per
// output beat, tlast on the final byte (a field can be empty: zero value, explicit
// precision zero, width zero give no beat at all). Width and precision above 48 are
// clamped to 48. A request takes an accept step, an issue and a wait step per digit in the
// shared digit unit (1 to 10 decimal digits, 1 to 8 hex digits) and a planning step, then
// one byte per cycle while the output is taken (up to 49 bytes). s_tready returns once
// the last byte is loaded into the output register, so the next request is taken while
// that byte still waits.
`default_nettype none

module padded_integer_field_formatter
    import pifr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: value[31:0], field_width[37:32], min_digits[43:38], has_precision[44]
    input  wire logic [47:0] s_tdata,
    // tuser: operation[0]
    input  wire logic        s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: character[7:0]
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    pifr_state_t state_reg, state_next;

    logic                 hex_reg,       hex_next;
    logic                 neg_reg,       neg_next;
    logic                 kill_reg,      kill_next;
    logic [5:0]           width_reg,     width_next;
    logic [5:0]           prec_reg,      prec_next;
    logic [31:0]          mag_reg,       mag_next;
    logic [3:0]           digit_reg [DIGITS_MAX];
    logic [3:0]           digit_next [DIGITS_MAX];
    logic [DIG_IDX_W:0]   ndig_reg,      ndig_next;
    logic [5:0]           pad_reg,       pad_next;
    logic [5:0]           zeros_reg,     zeros_next;
    logic                 sign_reg,      sign_next;
    logic [DIG_IDX_W:0]   dig_cnt_reg,   dig_cnt_next;
    logic [5:0]           remain_reg,    remain_next;
    logic                 m_tvalid_reg,  m_tvalid_next;
    logic [7:0]           m_tdata_reg,   m_tdata_next;
    logic                 m_tlast_reg,   m_tlast_next;

    du_req_t du_req;
    du_rsp_t du_rsp;

    logic               out_free;
    logic [DIG_IDX_W:0] ndig_eff;
    logic [5:0]         zeros_c;
    logic [5:0]         body_c;
    logic [5:0]         pad_c;
    logic [5:0]         total_c;
    logic [DIG_IDX_W:0] rd_idx;
    logic [31:0]        in_value;

    pifr_digit_unit u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (du_req),
        .rsp     (du_rsp)
    );

    assign in_value = s_tdata[31:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_idx   = dig_cnt_reg - 1'b1;

    // Field layout from the digit count
    always_comb begin
        ndig_eff = kill_reg ? '0 : ndig_reg;
        zeros_c  = (prec_reg > 6'(ndig_eff)) ? (prec_reg - 6'(ndig_eff)) : 6'd0;
        body_c   = 6'(neg_reg) + zeros_c + 6'(ndig_eff);
        pad_c    = (width_reg > body_c) ? (width_reg - body_c) : 6'd0;
        total_c  = pad_c + body_c;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (du_rsp.done) begin
                    state_next = (du_rsp.quot == 32'd0) ? ST_PLAN : ST_ISSUE;
                end
            end
            ST_PLAN:  state_next = (total_c == 6'd0) ? ST_IDLE : ST_EMIT;
            ST_EMIT: begin
                if (out_free && remain_reg == 6'd1) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs per state
    always_comb begin
        hex_next      = hex_reg;
        neg_next      = neg_reg;
        kill_next     = kill_reg;
        width_next    = width_reg;
        prec_next     = prec_reg;
        mag_next      = mag_reg;
        digit_next    = digit_reg;
        ndig_next     = ndig_reg;
        pad_next      = pad_reg;
        zeros_next    = zeros_reg;
        sign_next     = sign_reg;
        dig_cnt_next  = dig_cnt_reg;
        remain_next   = remain_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        du_req.start  = 1'b0;
        du_req.hex    = hex_reg;
        du_req.mag    = mag_reg;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    hex_next   = (s_tuser == OP_HEX);
                    neg_next   = (s_tuser == OP_DEC) && in_value[31];
                    mag_next   = neg_next ? (32'd0 - in_value) : in_value;
                    width_next = clamp_len(s_tdata[37:32]);
                    prec_next  = s_tdata[44] ? clamp_len(s_tdata[43:38]) : 6'd0;
                    kill_next  = (in_value == 32'd0) && s_tdata[44] && (prec_next == 6'd0);
                    ndig_next  = '0;
                end
            end
            ST_ISSUE: begin
                du_req.start = 1'b1;
            end
            ST_WAIT: begin
                // store digits least significant first
                if (du_rsp.done) begin
                    digit_next[ndig_reg[DIG_IDX_W-1:0]] = du_rsp.digit;
                    ndig_next = ndig_reg + 1'b1;
                    mag_next  = du_rsp.quot;
                end
            end
            ST_PLAN: begin
                pad_next     = pad_c;
                zeros_next   = zeros_c;
                sign_next    = neg_reg;
                dig_cnt_next = ndig_eff;
                remain_next  = total_c;
            end
            ST_EMIT: begin
                // spaces, sign, zeros, then digits most significant first
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (remain_reg == 6'd1);
                    remain_next   = remain_reg - 6'd1;
                    if (pad_reg != 6'd0) begin
                        m_tdata_next = CH_SPACE;
                        pad_next     = pad_reg - 6'd1;
                    end else if (sign_reg) begin
                        m_tdata_next = CH_MINUS;
                        sign_next    = 1'b0;
                    end else if (zeros_reg != 6'd0) begin
                        m_tdata_next = CH_ZERO;
                        zeros_next   = zeros_reg - 6'd1;
                    end else begin
                        m_tdata_next = digit_ascii(digit_reg[rd_idx[DIG_IDX_W-1:0]]);
                        dig_cnt_next = rd_idx;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hex_reg     <= hex_next;
        neg_reg     <= neg_next;
        kill_reg    <= kill_next;
        width_reg   <= width_next;
        prec_reg    <= prec_next;
        mag_reg     <= mag_next;
        digit_reg   <= digit_next;
        ndig_reg    <= ndig_next;
        pad_reg     <= pad_next;
        zeros_reg   <= zeros_next;
        sign_reg    <= sign_next;
        dig_cnt_reg <= dig_cnt_next;
        remain_reg  <= remain_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pifr_checker.sv
// Port-level checker for the padded integer field formatter, with its bind.
// Depends on padded_integer_field_formatter_defines.svh.
`default_nettype none
`include "padded_integer_field_formatter_defines.svh"

module pifr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    // stalled result stays offered
    `PIFR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // stalled result keeps its payload
    `PIFR_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // an accepted request makes the block busy
    `PIFR_ASSERT_NXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready right after a request")

    // no new request while a field is still being sent
    `PIFR_ASSERT_IMP(a_busy_mid_field, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "ready in the middle of a field")

endmodule

bind padded_integer_field_formatter pifr_checker u_pifr_checker (.*);

`default_nettype wire
